// File: sv/tlg_pkg.sv
// ----------------------------------------------------------------------------
// tlg_pkg
// Shared types, constants and the next-generation row function of the
// toroidal life generation engine.
// ----------------------------------------------------------------------------
package tlg_pkg;

  // Grid shape
  localparam int GRID_ROWS = 64;
  localparam int GRID_COLS = 64;
  localparam int ROW_W     = $clog2(GRID_ROWS);
  localparam int COL_W     = $clog2(GRID_COLS);
  // Sweep counter covers GRID_ROWS + 2 row reads
  localparam int CNT_W     = $clog2(GRID_ROWS + 2);

  // Rule B3/S23
  localparam logic [3:0] SURVIVE_LOW  = 4'd2;
  localparam logic [3:0] SURVIVE_HIGH = 4'd3;
  localparam logic [3:0] BIRTH_COUNT  = 4'd3;

  typedef logic [GRID_COLS-1:0] row_t;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_TOGGLE  = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_READ    = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CELL_RD,
    S_CELL_WB,
    S_ADV_RD,
    S_ADV_DRAIN
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;         // capture the input word
    logic cell_read;    // read the addressed row
    logic cell_finish;  // update the addressed row and post the result
    logic adv_start;    // clear the sweep counter
    logic adv_read;     // issue the next sweep read
    logic adv_finish;   // swap banks and post the done mark
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic adv_last;     // the sweep read issued now is the final one
  } sts_t;

  // Next generation of the middle row, columns wrapping around
  function automatic row_t life_row(row_t up, row_t mid, row_t dn);
    row_t       nxt;
    int         lc;
    int         rc;
    logic [3:0] n;
    for (int c = 0; c < GRID_COLS; c++) begin
      lc = (c == 0) ? GRID_COLS - 1 : c - 1;
      rc = (c == GRID_COLS - 1) ? 0 : c + 1;
      n  = 4'(up[lc]) + 4'(up[c]) + 4'(up[rc]) +
           4'(mid[lc]) + 4'(mid[rc]) +
           4'(dn[lc]) + 4'(dn[c]) + 4'(dn[rc]);
      nxt[c] = mid[c] ? (n == SURVIVE_LOW || n == SURVIVE_HIGH) : (n == BIRTH_COUNT);
    end
    return nxt;
  endfunction

endpackage

// File: sv/tlg_ram.sv
// ----------------------------------------------------------------------------
// tlg_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module tlg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/tlg_ctrl.sv
// ----------------------------------------------------------------------------
// tlg_ctrl
// Controller: sequences cell operations and the generation sweep.
// ----------------------------------------------------------------------------
module tlg_ctrl
  import tlg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] opcode_i,
  input  sts_t       sts_i,
  output logic       busy,
  output cmd_t       cmd_o
);

  state_e state_q;
  state_e state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          if (opcode_e'(opcode_i) == OP_ADVANCE) begin
            cmd_o.adv_start = 1'b1;
            state_d         = S_ADV_RD;
          end else begin
            state_d = S_CELL_RD;
          end
        end
      end
      S_CELL_RD: begin
        cmd_o.cell_read = 1'b1;
        state_d         = S_CELL_WB;
      end
      S_CELL_WB: begin
        cmd_o.cell_finish = 1'b1;
        state_d           = S_IDLE;
      end
      S_ADV_RD: begin
        cmd_o.adv_read = 1'b1;
        if (sts_i.adv_last) begin
          state_d = S_ADV_DRAIN;
        end
      end
      S_ADV_DRAIN: begin
        cmd_o.adv_finish = 1'b1;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

// File: sv/tlg_datapath.sv
// ----------------------------------------------------------------------------
// tlg_datapath
// Two grid banks, row valid bits, the three-row sweep window and the
// result registers.
// ----------------------------------------------------------------------------
module tlg_datapath
  import tlg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  logic [1:0] opcode_i,
  input  logic [5:0] row_i,
  input  logic [5:0] col_i,
  input  logic       cell_value_i,
  output sts_t       sts_o,
  output logic       result_valid_o,
  output logic       cell_alive_o,
  output logic       generation_done_o
);

  // Captured input word
  opcode_e op_q;
  logic [5:0] row_q;
  logic [5:0] col_q;
  logic       val_q;

  // Bank select and row valid bits of the current bank
  logic                 bank_q;
  logic [GRID_ROWS-1:0] valid_q;

  // Sweep state
  logic [CNT_W-1:0] cnt_q;
  logic             pend_q;
  logic [CNT_W-1:0] pend_idx_q;
  row_t             win_a_q;
  row_t             win_b_q;

  // Read path
  logic [ROW_W-1:0] raddr;
  logic [ROW_W-1:0] adv_raddr;
  logic             rd_vld_q;
  row_t             rdata0;
  row_t             rdata1;
  row_t             rdata;

  // Write path
  logic             cell_we;
  logic             adv_we;
  logic             wr_bank;
  logic [ROW_W-1:0] waddr;
  row_t             wdata;
  row_t             new_row;
  row_t             adv_row;
  logic             in_range;
  logic [ROW_W-1:0] row_addr;
  logic [COL_W-1:0] col_idx;

  // Result registers
  logic res_vld_q;
  logic res_alive_q;
  logic res_gen_q;

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_e'(opcode_i);
      row_q <= row_i;
      col_q <= col_i;
      val_q <= cell_value_i;
    end
  end

  assign in_range = (32'(row_q) < GRID_ROWS) && (32'(col_q) < GRID_COLS);
  assign row_addr = ROW_W'(row_q);
  assign col_idx  = COL_W'(col_q);

  // Sweep read order: last row, then every row, then row zero again
  always_comb begin
    if (cnt_q == '0) begin
      adv_raddr = ROW_W'(GRID_ROWS - 1);
    end else if (cnt_q == CNT_W'(GRID_ROWS + 1)) begin
      adv_raddr = '0;
    end else begin
      adv_raddr = ROW_W'(cnt_q - CNT_W'(1));
    end
  end

  assign raddr          = cmd_i.cell_read ? row_addr : adv_raddr;
  assign sts_o.adv_last = (cnt_q == CNT_W'(GRID_ROWS + 1));

  // Advance the sweep counter and track the read in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      pend_q     <= 1'b0;
      pend_idx_q <= '0;
    end else begin
      if (cmd_i.adv_start) begin
        cnt_q <= '0;
      end else if (cmd_i.adv_read) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      pend_q     <= cmd_i.adv_read;
      pend_idx_q <= cnt_q;
    end
  end

  // Grid banks
  tlg_ram #(
    .WIDTH(GRID_COLS),
    .DEPTH(GRID_ROWS)
  ) u_bank0 (
    .clk_i  (clk_i),
    .we_i   ((cell_we || adv_we) && !wr_bank),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata0)
  );

  tlg_ram #(
    .WIDTH(GRID_COLS),
    .DEPTH(GRID_ROWS)
  ) u_bank1 (
    .clk_i  (clk_i),
    .we_i   ((cell_we || adv_we) && wr_bank),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata1)
  );

  // Rows never written since reset read as dead
  always_ff @(posedge clk_i) begin
    rd_vld_q <= valid_q[raddr];
  end

  assign rdata = (bank_q ? rdata1 : rdata0) & {GRID_COLS{rd_vld_q}};

  // Shift the three-row window
  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      win_a_q <= win_b_q;
      win_b_q <= rdata;
    end
  end

  assign adv_row = life_row(win_a_q, win_b_q, rdata);
  assign adv_we  = pend_q && (pend_idx_q >= CNT_W'(2));

  // Apply a write or toggle to the addressed row
  always_comb begin
    new_row = rdata;
    case (op_q)
      OP_WRITE:  new_row[col_idx] = val_q;
      OP_TOGGLE: new_row[col_idx] = ~rdata[col_idx];
      default:   new_row = rdata;
    endcase
  end

  assign cell_we = cmd_i.cell_finish && in_range &&
                   (op_q == OP_WRITE || op_q == OP_TOGGLE);

  // Sweep writes the other bank, cell updates the current one
  assign wr_bank = adv_we ? ~bank_q : bank_q;
  assign waddr   = adv_we ? ROW_W'(pend_idx_q - CNT_W'(2)) : row_addr;
  assign wdata   = adv_we ? adv_row : new_row;

  // Swap banks and track valid rows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q  <= 1'b0;
      valid_q <= '0;
    end else if (cmd_i.adv_finish) begin
      bank_q  <= ~bank_q;
      valid_q <= '1;
    end else if (cell_we) begin
      valid_q[row_addr] <= 1'b1;
    end
  end

  // Post one result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= cmd_i.cell_finish || cmd_i.adv_finish;
    end
  end

  always_ff @(posedge clk_i) begin
    res_alive_q <= cmd_i.cell_finish && in_range && new_row[col_idx];
    res_gen_q   <= cmd_i.adv_finish;
  end

  assign result_valid_o    = res_vld_q;
  assign cell_alive_o      = res_alive_q;
  assign generation_done_o = res_gen_q;

endmodule

// File: sv/toroidal_life_generation_engine.sv
// ----------------------------------------------------------------------------
// toroidal_life_generation_engine
// Game of life (B3/S23) on a wrapping grid: write, toggle or read one cell,
// or advance the whole grid by one generation.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  --------  ---------------------  ----------------------------------------
//  command   start && !busy         opcode_i, row_i, col_i, cell_value_i
//  result    result_valid_o (1 cy)  cell_alive_o, generation_done_o
//
// A cell operation runs from accept to result strobe through a row read
// from the grid bank RAM, a read-modify-write cycle and the result register.
// An advance sweeps the whole grid: it reads one row per cycle from the
// single read port, GRID_ROWS + 2 reads in all, and writes one whole new
// row per cycle into the other bank, then swaps banks.
// Reset clears the row valid bits, so the grid reads as all dead at once.
// The result strobe lasts one cycle and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module toroidal_life_generation_engine
  import tlg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] opcode_i,
  input  logic [5:0] row_i,
  input  logic [5:0] col_i,
  input  logic       cell_value_i,
  output logic       result_valid_o,
  output logic       cell_alive_o,
  output logic       generation_done_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequence the operations
  tlg_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .opcode_i(opcode_i),
    .sts_i   (sts),
    .busy    (busy),
    .cmd_o   (cmd)
  );

  // Hold the grid and compute
  tlg_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .opcode_i         (opcode_i),
    .row_i            (row_i),
    .col_i            (col_i),
    .cell_value_i     (cell_value_i),
    .sts_o            (sts),
    .result_valid_o   (result_valid_o),
    .cell_alive_o     (cell_alive_o),
    .generation_done_o(generation_done_o)
  );

endmodule
